// ===== rtl/ate_pkg.sv =====
// Shared types and constants for the ANSI text terminal engine.
// Used by ate_ctrl, ate_datapath and the top level; no dependencies.
package ate_pkg;

  // Result operation codes
  localparam logic [1:0] OP_STATUS = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;
  localparam logic [1:0] OP_SCROLL = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_DEFCOL  = 2'd2;

  // Request types
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_RESET = 1'b1;

  // Terminal bytes
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] FINAL_LO = 8'h40;
  localparam logic [7:0] FINAL_HI = 8'h7e;

  // CSI final bytes
  localparam logic [7:0] CSI_CUU = 8'h41; // A
  localparam logic [7:0] CSI_CUD = 8'h42; // B
  localparam logic [7:0] CSI_CUF = 8'h43; // C
  localparam logic [7:0] CSI_CUB = 8'h44; // D
  localparam logic [7:0] CSI_CHA = 8'h47; // G
  localparam logic [7:0] CSI_CUP = 8'h48; // H
  localparam logic [7:0] CSI_HVP = 8'h66; // f
  localparam logic [7:0] CSI_ED  = 8'h4a; // J
  localparam logic [7:0] CSI_EL  = 8'h4b; // K
  localparam logic [7:0] CSI_SGR = 8'h6d; // m
  localparam logic [7:0] CSI_SM  = 8'h68; // h
  localparam logic [7:0] CSI_RM  = 8'h6c; // l

  localparam logic [15:0] ACC_MAX = 16'hffff;

  // What an accepted item turns out to need
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RESET,
    ACT_PLAIN,
    ACT_CSI
  } act_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic calc_total;
    logic parse;
    logic div_step;
    logic mul;
    logic sgr_step;
    logic exec;
    logic emit;
  } ate_cmd_t;

  // Datapath to controller
  typedef struct packed {
    act_e act;
    logic div_last;
    logic is_sgr;
    logic sgr_more;
    logic emit_done;
  } ate_stat_t;

endpackage

// ===== rtl/ate_ctrl.sv =====
// Sequencing state machine of the terminal engine.
// Depends on ate_pkg for the command and status structs.
module ate_ctrl import ate_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ate_stat_t stat_i,
  output ate_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOTAL,
    S_PARSE,
    S_DIV,
    S_MUL,
    S_SGR,
    S_EXEC,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd_o.calc_total = 1'b1;
        state_d          = S_PARSE;
      end
      S_PARSE: begin
        cmd_o.parse = 1'b1;
        case (stat_i.act)
          ACT_NONE:  state_d = S_IDLE;
          ACT_RESET: state_d = S_EMIT;
          default:   state_d = S_DIV;
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.is_sgr ? S_SGR : S_EXEC;
      end
      S_SGR: begin
        if (stat_i.sgr_more) cmd_o.sgr_step = 1'b1;
        else state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/ate_datapath.sv =====
// Datapath of the terminal engine: config, parser, cursor, SGR state,
// column divider, multiplier, result list and output register. Uses ate_pkg.
module ate_datapath import ate_pkg::*; #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 128,
  parameter int MAX_PARAMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ate_cmd_t    cmd_i,
  output ate_stat_t   stat_o,
  // configuration
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  // item in
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  clear_color_i,
  // result out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  op_o,
  output logic [14:0] start_pos_o,
  output logic [14:0] end_pos_o,
  output logic [7:0]  char_code_out_o,
  output logic [7:0]  color_o,
  output logic [14:0] cursor_pos_o,
  output logic        cursor_on_o,
  output logic        last_o
);

  localparam int QW  = $clog2(MAX_ROWS);
  localparam int DCW = $clog2(QW + 1);
  localparam int CW  = $clog2(MAX_PARAMS + 1);
  localparam int IW  = $clog2(MAX_PARAMS);
  localparam logic [8:0]    MaxCols = 9'(MAX_COLS);
  localparam logic [7:0]    MaxRows = 8'(MAX_ROWS);
  localparam logic [DCW-1:0] DivTop = DCW'(QW - 1);
  localparam logic [CW-1:0]  PMax   = CW'(MAX_PARAMS);

  typedef enum logic [1:0] {
    PM_IDLE,
    PM_ESC,
    PM_CSI
  } pmode_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] spos;
    logic [14:0] epos;
    logic [7:0]  ch;
    logic [7:0]  col;
    logic [14:0] cpos;
    logic        con;
    logic        last;
  } res_t;

  function automatic res_t mk_cmd(logic [1:0] op, logic [14:0] s, logic [14:0] e,
                                  logic [7:0] ch, logic [7:0] col);
    res_t r;
    r      = '0;
    r.op   = op;
    r.spos = s;
    r.epos = e;
    r.ch   = ch;
    r.col  = col;
    return r;
  endfunction

  function automatic logic [7:0] compose(logic [3:0] fg, logic [3:0] bg,
                                         logic bold, logic rev);
    logic [3:0] f;
    f = fg;
    if (bold && !f[3]) f = f + 4'd8;
    return rev ? {f, bg} : {bg, f};
  endfunction

  // Configuration registers
  logic [8:0] columns_q;
  logic [7:0] rows_q, defc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 9'd80;
      rows_q    <= 8'd25;
      defc_q    <= 8'd7;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COLUMNS: columns_q <= cfg_data_i;
        REG_ROWS:    rows_q    <= cfg_data_i[7:0];
        REG_DEFCOL:  defc_q    <= cfg_data_i[7:0];
        default:     ;
      endcase
    end
  end

  // Saturated geometry
  logic [8:0] cols;
  logic [7:0] rws;
  assign cols = (columns_q == 9'd0) ? 9'd1 : ((columns_q > MaxCols) ? MaxCols : columns_q);
  assign rws  = (rows_q == 8'd0) ? 8'd1 : ((rows_q > MaxRows) ? MaxRows : rows_q);

  // State
  logic        req_q;
  logic [7:0]  ch_q, clr_q;
  logic [15:0] total_q;
  logic [14:0] cur_q, rem_q;
  logic [DCW-1:0] dk_q;
  logic [24:0] mul_q;
  pmode_e      mode_q;
  logic [15:0] acc_q;
  logic [15:0] plist_q [MAX_PARAMS];
  logic [CW-1:0] pcnt_q, sidx_q;
  logic        priv_q;
  logic [3:0]  fg_q, bg_q;
  logic        bold_q, rev_q, cen_q;
  logic [7:0]  draw_q;
  act_e        act_q;
  res_t        res_q [3];
  logic [1:0]  rn_q, eidx_q;
  res_t        out_q;
  logic        ovalid_q;

  // Cursor clamp and parse decision
  logic [14:0] cur_cl;
  logic [14:0] tot_m1;
  logic        is_digit, is_final;
  act_e        act_now;
  logic [19:0] acc_x;
  logic [15:0] acc_n;

  assign tot_m1   = 15'(total_q - 16'd1);
  assign cur_cl   = ({1'b0, cur_q} >= total_q) ? tot_m1 : cur_q;
  assign is_digit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign is_final = (ch_q >= FINAL_LO) && (ch_q <= FINAL_HI);
  assign acc_x    = {acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {16'b0, ch_q[3:0]};
  assign acc_n    = (acc_x > {4'b0, ACC_MAX}) ? ACC_MAX : acc_x[15:0];

  always_comb begin
    act_now = ACT_PLAIN;
    if (req_q == REQ_RESET) begin
      act_now = ACT_RESET;
    end else begin
      case (mode_q)
        PM_ESC: if (ch_q == CH_LBRK) act_now = ACT_NONE;
        PM_CSI: begin
          if (is_digit || ch_q == CH_SEMI || ch_q == CH_QMARK) act_now = ACT_NONE;
          else if (is_final) act_now = ACT_CSI;
        end
        default: if (ch_q == CH_ESC) act_now = ACT_NONE;
      endcase
    end
  end

  // Parameter views
  logic [15:0] p0, n16, sgr_p, arow, bcol, ag;
  assign p0    = (pcnt_q != '0) ? plist_q[0] : 16'd0;
  assign n16   = (p0 == 16'd0) ? 16'd1 : p0;
  assign sgr_p = plist_q[sidx_q[IW-1:0]];

  always_comb begin
    arow = n16 - 16'd1;
    if (arow >= {8'b0, rws}) arow = {8'b0, rws} - 16'd1;
    bcol = (pcnt_q >= CW'(2)) ? plist_q[1] : 16'd1;
    if (bcol == 16'd0) bcol = 16'd1;
    bcol = bcol - 16'd1;
    if (bcol >= {7'b0, cols}) bcol = {7'b0, cols} - 16'd1;
    ag = ((pcnt_q == '0) || (p0 == 16'd0)) ? 16'd0 : p0 - 16'd1;
    if (ag >= {7'b0, cols}) ag = {7'b0, cols} - 16'd1;
  end

  logic is_cup;
  assign is_cup = (ch_q == CSI_CUP) || (ch_q == CSI_HVP);

  // Divider step: strip cols << k from the remainder
  logic [15:0] dsub;
  assign dsub = {7'b0, cols} << dk_q;

  // Execute: build commands and next cursor
  logic [14:0] rowst, rowend, ex_cur;
  logic [15:0] nl, lastrow, t16;
  logic [25:0] t26;
  logic [9:0]  nx;
  logic        ex_cen;
  logic [7:0]  ex_draw;
  res_t        c0, c1;
  logic [1:0]  ncmd;

  assign rowst   = cur_q - rem_q;
  assign rowend  = 15'({1'b0, rowst} + {7'b0, cols} - 16'd1);
  assign nl      = {1'b0, rowst} + {7'b0, cols};
  assign lastrow = total_q - {7'b0, cols};
  assign nx      = ({1'b0, rem_q[8:0]} + 10'd8) & ~10'd7;

  always_comb begin
    ex_cur  = cur_q;
    ex_cen  = cen_q;
    ex_draw = draw_q;
    c0      = '0;
    c1      = '0;
    ncmd    = 2'd0;
    t16     = '0;
    t26     = '0;
    if (act_q == ACT_PLAIN) begin
      case (ch_q)
        CH_LF, CH_TAB: begin
          if (ch_q == CH_TAB && nx < {1'b0, cols}) begin
            ex_cur = rowst + {5'b0, nx};
          end else if (nl >= total_q) begin
            c0     = mk_cmd(OP_SCROLL, 15'd0, 15'd0, CH_SPACE, draw_q);
            ncmd   = 2'd1;
            ex_cur = lastrow[14:0];
          end else begin
            ex_cur = nl[14:0];
          end
        end
        CH_CR: ex_cur = rowst;
        CH_BS, CH_DEL: begin
          if (cur_q != 15'd0) begin
            ex_cur = cur_q - 15'd1;
            c0     = mk_cmd(OP_WRITE, ex_cur, ex_cur, CH_SPACE, draw_q);
            ncmd   = 2'd1;
          end
        end
        default: begin
          if (ch_q >= CH_SPACE) begin
            c0   = mk_cmd(OP_WRITE, cur_q, cur_q, ch_q, draw_q);
            ncmd = 2'd1;
            t16  = {1'b0, cur_q} + 16'd1;
            if (t16 >= total_q) begin
              c1     = mk_cmd(OP_SCROLL, 15'd0, 15'd0, CH_SPACE, draw_q);
              ncmd   = 2'd2;
              ex_cur = lastrow[14:0];
            end else begin
              ex_cur = t16[14:0];
            end
          end
        end
      endcase
    end else begin
      case (ch_q)
        CSI_SGR: ex_draw = compose(fg_q, bg_q, bold_q, rev_q);
        CSI_CUU: ex_cur = ({10'b0, cur_q} >= mul_q) ? cur_q - mul_q[14:0] : rowst;
        CSI_CUD: begin
          t26 = {11'b0, cur_q} + {1'b0, mul_q};
          if (t26 >= {10'b0, total_q}) ex_cur = 15'(lastrow + {1'b0, rem_q});
          else ex_cur = t26[14:0];
        end
        CSI_CUF: begin
          t26 = {11'b0, cur_q} + {10'b0, n16};
          ex_cur = (t26 >= {10'b0, total_q}) ? tot_m1 : t26[14:0];
        end
        CSI_CUB: ex_cur = ({1'b0, cur_q} >= n16) ? 15'({1'b0, cur_q} - n16) : rowst;
        CSI_SM, CSI_RM: if (priv_q && n16 == 16'd25) ex_cen = (ch_q == CSI_SM);
        CSI_ED: begin
          ncmd = 2'd1;
          if (p0 == 16'd2 || p0 == 16'd3) begin
            c0 = mk_cmd(OP_FILL, 15'd0, tot_m1, CH_SPACE, draw_q);
            if (p0 == 16'd2) ex_cur = 15'd0;
          end else if (p0 == 16'd1) begin
            c0 = mk_cmd(OP_FILL, 15'd0, cur_q, CH_SPACE, draw_q);
          end else begin
            c0 = mk_cmd(OP_FILL, cur_q, tot_m1, CH_SPACE, draw_q);
          end
        end
        CSI_EL: begin
          ncmd = 2'd1;
          if (p0 == 16'd2) c0 = mk_cmd(OP_FILL, rowst, rowend, CH_SPACE, draw_q);
          else if (p0 == 16'd1) c0 = mk_cmd(OP_FILL, rowst, cur_q, CH_SPACE, draw_q);
          else c0 = mk_cmd(OP_FILL, cur_q, rowend, CH_SPACE, draw_q);
        end
        CSI_CHA: ex_cur = rowst + ag[14:0];
        CSI_CUP, CSI_HVP: ex_cur = mul_q[14:0] + bcol[14:0];
        default: ;
      endcase
    end
  end

  // Status record
  res_t ex_stat, rst_stat;
  always_comb begin
    ex_stat      = '0;
    ex_stat.op   = OP_STATUS;
    ex_stat.cpos = ex_cur;
    ex_stat.con  = ex_cen;
    ex_stat.last = 1'b1;
    rst_stat      = '0;
    rst_stat.op   = OP_STATUS;
    rst_stat.con  = cen_q;
    rst_stat.last = 1'b1;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= PM_IDLE;
      acc_q    <= '0;
      pcnt_q   <= '0;
      priv_q   <= 1'b0;
      fg_q     <= 4'd7;
      bg_q     <= 4'd0;
      bold_q   <= 1'b0;
      rev_q    <= 1'b0;
      draw_q   <= 8'd7;
      cur_q    <= '0;
      cen_q    <= 1'b1;
      act_q    <= ACT_NONE;
      ovalid_q <= 1'b0;
      eidx_q   <= '0;
      rn_q     <= '0;
      dk_q     <= '0;
      sidx_q   <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;

      if (cmd_i.parse) begin
        act_q  <= act_now;
        cur_q  <= cur_cl;
        dk_q   <= DivTop;
        sidx_q <= '0;
        eidx_q <= '0;
        case (act_now)
          ACT_RESET: begin
            mode_q <= PM_IDLE;
            acc_q  <= '0;
            pcnt_q <= '0;
            priv_q <= 1'b0;
            fg_q   <= defc_q[3:0];
            bg_q   <= defc_q[7:4];
            bold_q <= 1'b0;
            rev_q  <= 1'b0;
            draw_q <= clr_q;
            cur_q  <= '0;
            rn_q   <= 2'd2;
          end
          ACT_NONE: begin
            if (mode_q == PM_IDLE) begin
              mode_q <= PM_ESC;
            end else if (mode_q == PM_ESC) begin
              mode_q <= PM_CSI;
              acc_q  <= '0;
              pcnt_q <= '0;
            end else if (is_digit) begin
              acc_q <= acc_n;
            end else if (ch_q == CH_SEMI) begin
              if (pcnt_q < PMax) pcnt_q <= pcnt_q + CW'(1);
              acc_q <= '0;
            end else begin
              priv_q <= 1'b1;
            end
          end
          ACT_CSI: begin
            if (pcnt_q < PMax) pcnt_q <= pcnt_q + CW'(1);
            acc_q <= '0;
          end
          default: begin
            mode_q <= PM_IDLE;
            acc_q  <= '0;
            pcnt_q <= '0;
            priv_q <= 1'b0;
          end
        endcase
      end

      if (cmd_i.div_step) dk_q <= dk_q - DCW'(1);

      // One SGR parameter per cycle
      if (cmd_i.sgr_step) begin
        sidx_q <= sidx_q + CW'(1);
        if (sgr_p == 16'd0) begin
          fg_q   <= defc_q[3:0];
          bg_q   <= defc_q[7:4];
          bold_q <= 1'b0;
          rev_q  <= 1'b0;
        end else if (sgr_p == 16'd1) bold_q <= 1'b1;
        else if (sgr_p == 16'd22) bold_q <= 1'b0;
        else if (sgr_p == 16'd7) rev_q <= 1'b1;
        else if (sgr_p == 16'd27) rev_q <= 1'b0;
        else if (sgr_p >= 16'd30 && sgr_p <= 16'd37) fg_q <= 4'(sgr_p - 16'd30);
        else if (sgr_p >= 16'd90 && sgr_p <= 16'd97) fg_q <= 4'(sgr_p - 16'd82);
        else if (sgr_p >= 16'd40 && sgr_p <= 16'd47) bg_q <= 4'(sgr_p - 16'd40);
        else if (sgr_p >= 16'd100 && sgr_p <= 16'd107) bg_q <= 4'(sgr_p - 16'd92);
        else if (sgr_p == 16'd39) fg_q <= defc_q[3:0];
        else if (sgr_p == 16'd49) bg_q <= defc_q[7:4];
      end

      if (cmd_i.exec) begin
        cur_q  <= ex_cur;
        cen_q  <= ex_cen;
        draw_q <= ex_draw;
        rn_q   <= ncmd + 2'd1;
        mode_q <= PM_IDLE;
        acc_q  <= '0;
        pcnt_q <= '0;
        priv_q <= 1'b0;
      end

      // Hand the next pending result to the output register
      if (cmd_i.emit && (!ovalid_q || !out_stall_i)) begin
        ovalid_q <= 1'b1;
        eidx_q   <= eidx_q + 2'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_type_i;
      ch_q  <= char_code_i;
      clr_q <= clear_color_i;
    end
    if (cmd_i.calc_total) total_q <= 16'(cols * rws);
    if (cmd_i.parse) begin
      rem_q <= cur_cl;
      if (act_now == ACT_RESET) begin
        res_q[0] <= mk_cmd(OP_FILL, 15'd0, tot_m1, CH_SPACE, clr_q);
        res_q[1] <= rst_stat;
      end
      if (act_now == ACT_CSI && pcnt_q < PMax) plist_q[pcnt_q[IW-1:0]] <= acc_q;
      if (act_now == ACT_NONE && mode_q == PM_CSI && ch_q == CH_SEMI && pcnt_q < PMax) begin
        plist_q[pcnt_q[IW-1:0]] <= acc_q;
      end
    end
    if (cmd_i.div_step && ({1'b0, rem_q} >= dsub)) rem_q <= 15'({1'b0, rem_q} - dsub);
    if (cmd_i.mul) mul_q <= (is_cup ? arow : n16) * cols;
    if (cmd_i.exec) begin
      case (ncmd)
        2'd0: res_q[0] <= ex_stat;
        2'd1: begin
          res_q[0] <= c0;
          res_q[1] <= ex_stat;
        end
        default: begin
          res_q[0] <= c0;
          res_q[1] <= c1;
          res_q[2] <= ex_stat;
        end
      endcase
    end
    if (cmd_i.emit && (!ovalid_q || !out_stall_i)) out_q <= res_q[eidx_q];
  end

  // Status to the controller
  always_comb begin
    stat_o           = '0;
    stat_o.act       = act_now;
    stat_o.div_last  = (dk_q == '0);
    stat_o.is_sgr    = (act_q == ACT_CSI) && (ch_q == CSI_SGR);
    stat_o.sgr_more  = (sidx_q < pcnt_q);
    stat_o.emit_done = (!ovalid_q || !out_stall_i) && (eidx_q == rn_q - 2'd1);
  end

  assign out_valid_o     = ovalid_q;
  assign op_o            = out_q.op;
  assign start_pos_o     = out_q.spos;
  assign end_pos_o       = out_q.epos;
  assign char_code_out_o = out_q.ch;
  assign color_o         = out_q.col;
  assign cursor_pos_o    = out_q.cpos;
  assign cursor_on_o     = out_q.con;
  assign last_o          = out_q.last;

endmodule

// ===== rtl/ansi_text_terminal_engine.sv =====
// ANSI text terminal engine top level: controller plus datapath.
// Depends on ate_pkg, ate_ctrl and ate_datapath.
//
// Takes one terminal byte or screen reset request per item and produces
// screen commands (cell write, blank fill, scroll up) followed by a cursor
// status result flagged last. Bytes inside an escape sequence produce no
// result. A reset request produces a blank fill and then a status result.
// Any other byte runs a column divider of log2(MAX_ROWS) steps, a multiply,
// one SGR parameter per cycle for an 'm' sequence, then one result per
// cycle while the output is not stalled. The divider splits the linear
// cursor into row start and column. The output register lets the next item
// be taken while the last result still waits. Configuration writes are
// taken at any cycle but are meant to happen only while the engine is idle.
module ansi_text_terminal_engine import ate_pkg::*; #(
  parameter int MAX_COLS   = 256,
  parameter int MAX_ROWS   = 128,
  parameter int MAX_PARAMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  clear_color_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  op_o,
  output logic [14:0] start_pos_o,
  output logic [14:0] end_pos_o,
  output logic [7:0]  char_code_out_o,
  output logic [7:0]  color_o,
  output logic [14:0] cursor_pos_o,
  output logic        cursor_on_o,
  output logic        last_o
);

  ate_cmd_t  cmd;
  ate_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ate_datapath #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .clear_color_i   (clear_color_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .op_o            (op_o),
    .start_pos_o     (start_pos_o),
    .end_pos_o       (end_pos_o),
    .char_code_out_o (char_code_out_o),
    .color_o         (color_o),
    .cursor_pos_o    (cursor_pos_o),
    .cursor_on_o     (cursor_on_o),
    .last_o          (last_o)
  );

endmodule

// ===== tb/tb_ansi_text_terminal_engine.sv =====
// Self-checking testbench for the ANSI text terminal engine.
// Depends on ate_pkg and ansi_text_terminal_engine; predicts screen commands itself.
module tb_ansi_text_terminal_engine;
  import ate_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
    logic [7:0] clr;
  } term_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] start_pos;
    logic [14:0] end_pos;
    logic [7:0]  ch;
    logic [7:0]  color;
    logic [14:0] cursor_pos;
    logic        cursor_on;
    logic        last;
  } screen_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic [7:0]  clear_color_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  op_o;
  logic [14:0] start_pos_o, end_pos_o, cursor_pos_o;
  logic [7:0]  char_code_out_o, color_o;
  logic        cursor_on_o, last_o;

  ansi_text_terminal_engine DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shared bookkeeping
  term_item_t  byte_q[$];
  screen_cmd_t want_q[$];
  term_item_t  shown;
  int          cyc = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          hold_cnt = 0;
  bit          hold_done = 0;
  bit          quiet;

  assign quiet = (cyc >= 3000) && (cyc < 5000);

  // ---------------- predictor state ----------------
  int unsigned m_cols = 80, m_rows = 25, m_defcol = 7;
  int unsigned pmode, accum, pcount, priv;
  int unsigned plist[MAX_PARAMS_TB];
  localparam int MAX_PARAMS_TB = 4;
  int unsigned fg, bg, bold, rev, dcolor, cursor, cen;
  int          n_emit;

  task automatic emit_cmd(int unsigned op, int unsigned s, int unsigned e, int unsigned ch,
                          int unsigned col, int unsigned cur, int unsigned on,
                          int unsigned lst);
    screen_cmd_t r;
    if (n_emit >= 3) return;
    r.op = op[1:0]; r.start_pos = s[14:0]; r.end_pos = e[14:0]; r.ch = ch[7:0];
    r.color = col[7:0]; r.cursor_pos = cur[14:0]; r.cursor_on = on[0]; r.last = lst[0];
    want_q.push_back(r);
    n_emit++;
  endtask

  task automatic emit_fill(int unsigned s, int unsigned e);
    emit_cmd(OP_FILL, s, e, CH_SPACE, dcolor, 0, 0, 0);
  endtask

  task automatic parser_clear();
    pmode = 0; accum = 0; pcount = 0; priv = 0;
  endtask

  task automatic sgr_default();
    fg = m_defcol & 8'h0f; bg = (m_defcol >> 4) & 8'h0f; bold = 0; rev = 0;
  endtask

  task automatic sgr_update();
    int unsigned f, b, t;
    f = fg; b = bg;
    if (bold != 0 && f < 8) f += 8;
    if (rev != 0) begin
      t = f; f = b; b = t;
    end
    dcolor = ((b << 4) | f) & 8'hff;
  endtask

  task automatic push_param();
    if (pcount < MAX_PARAMS_TB) begin
      plist[pcount] = accum;
      pcount++;
    end
    accum = 0;
  endtask

  task automatic line_feed(int unsigned cols, int unsigned rws);
    int unsigned cur;
    cur = (cursor / cols + 1) * cols;
    if (cur >= cols * rws) begin
      emit_cmd(OP_SCROLL, 0, 0, CH_SPACE, dcolor, 0, 0, 0);
      cur = (rws - 1) * cols;
    end
    cursor = cur;
  endtask

  task automatic csi_run(int unsigned cmd, int unsigned cols, int unsigned rws);
    int unsigned total, cur, rowstart, p0, n, a, b, p;
    total = cols * rws; cur = cursor;
    rowstart = (cur / cols) * cols;
    p0 = (pcount > 0) ? plist[0] : 0;
    n = (pcount > 0) ? p0 : 1;
    if (n == 0) n = 1;
    case (cmd[7:0])
      CSI_SGR: begin
        for (int i = 0; i < pcount && i < MAX_PARAMS_TB; i++) begin
          p = plist[i];
          if (p == 0) sgr_default();
          else if (p == 1) bold = 1;
          else if (p == 22) bold = 0;
          else if (p == 7) rev = 1;
          else if (p == 27) rev = 0;
          else if (p >= 30 && p <= 37) fg = p - 30;
          else if (p >= 90 && p <= 97) fg = p - 90 + 8;
          else if (p >= 40 && p <= 47) bg = p - 40;
          else if (p >= 100 && p <= 107) bg = p - 100 + 8;
          else if (p == 39) fg = m_defcol & 8'h0f;
          else if (p == 49) bg = (m_defcol >> 4) & 8'h0f;
        end
        sgr_update();
      end
      CSI_CUU: cur = (cur >= n * cols) ? cur - n * cols : rowstart;
      CSI_CUD: begin
        cur += n * cols;
        if (cur >= total) cur = (rws - 1) * cols + cur % cols;
      end
      CSI_CUF: begin
        cur += n;
        if (cur >= total) cur = total - 1;
      end
      CSI_CUB: cur = (cur >= n) ? cur - n : rowstart;
      CSI_SM, CSI_RM: if (priv != 0 && n == 25) cen = (cmd[7:0] == CSI_SM) ? 1 : 0;
      CSI_ED: begin
        if (p0 == 2 || p0 == 3) begin
          emit_fill(0, total - 1);
          if (p0 == 2) cur = 0;
        end else if (p0 == 1) emit_fill(0, cur);
        else emit_fill(cur, total - 1);
      end
      CSI_EL: begin
        if (p0 == 2) emit_fill(rowstart, rowstart + cols - 1);
        else if (p0 == 1) emit_fill(rowstart, cur);
        else emit_fill(cur, rowstart + cols - 1);
      end
      CSI_CHA: begin
        a = (pcount > 0) ? p0 : 1;
        a = (a == 0) ? 0 : a - 1;
        if (a >= cols) a = cols - 1;
        cur = rowstart + a;
      end
      CSI_CUP, CSI_HVP: begin
        a = (pcount >= 1) ? p0 : 1;
        b = (pcount >= 2) ? plist[1] : 1;
        if (a < 1) a = 1;
        if (b < 1) b = 1;
        a--; b--;
        if (a >= rws) a = rws - 1;
        if (b >= cols) b = cols - 1;
        cur = a * cols + b;
      end
      default: ;
    endcase
    cursor = cur & 15'h7fff;
  endtask

  task automatic plain_char(int unsigned c, int unsigned cols, int unsigned rws);
    int unsigned cur, nx;
    cur = cursor;
    if (c == CH_LF) line_feed(cols, rws);
    else if (c == CH_CR) cursor = (cur / cols) * cols;
    else if (c == CH_BS || c == CH_DEL) begin
      if (cur > 0) begin
        cursor = cur - 1;
        emit_cmd(OP_WRITE, cursor, cursor, CH_SPACE, dcolor, 0, 0, 0);
      end
    end else if (c == CH_TAB) begin
      nx = ((cur % cols) + 8) & ~32'd7;
      if (nx >= cols) line_feed(cols, rws);
      else cursor = (cur / cols) * cols + nx;
    end else if (c >= CH_SPACE) begin
      emit_cmd(OP_WRITE, cur, cur, c, dcolor, 0, 0, 0);
      cur++;
      if (cur >= cols * rws) begin
        emit_cmd(OP_SCROLL, 0, 0, CH_SPACE, dcolor, 0, 0, 0);
        cur = (rws - 1) * cols;
      end
      cursor = cur;
    end
  endtask

  // Work out every screen command one accepted item causes
  task automatic predict_item(term_item_t it);
    int unsigned cols, rws, total, c;
    bit plain;
    n_emit = 0; plain = 0;
    cols = m_cols; rws = m_rows;
    if (cols < 1) cols = 1;
    if (cols > 256) cols = 256;
    if (rws < 1) rws = 1;
    if (rws > 128) rws = 128;
    total = cols * rws;
    if (cursor >= total) cursor = total - 1;
    if (it.req == REQ_RESET) begin
      parser_clear();
      sgr_default();
      dcolor = it.clr;
      cursor = 0;
      emit_fill(0, total - 1);
      emit_cmd(OP_STATUS, 0, 0, 0, 0, cursor, cen, 1);
      return;
    end
    c = it.ch;
    if (pmode == 1) begin
      if (c == CH_LBRK) begin
        pmode = 2; accum = 0; pcount = 0;
        return;
      end
      parser_clear();
      plain = 1;
    end else if (pmode == 2) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        accum = accum * 10 + (c - CH_ZERO);
        if (accum > ACC_MAX) accum = ACC_MAX;
        return;
      end
      if (c == CH_SEMI) begin
        push_param();
        return;
      end
      if (c == CH_QMARK) begin
        priv = 1;
        return;
      end
      if (c >= FINAL_LO && c <= FINAL_HI) begin
        push_param();
        csi_run(c, cols, rws);
        parser_clear();
      end else begin
        parser_clear();
        plain = 1;
      end
    end else if (c == CH_ESC) begin
      pmode = 1;
      return;
    end else begin
      pmode = 0;
      plain = 1;
    end
    if (plain) plain_char(c, cols, rws);
    emit_cmd(OP_STATUS, 0, 0, 0, 0, cursor, cen, 1);
  endtask

  // ---------------- stimulus helpers ----------------
  task automatic add_byte(int unsigned c);
    term_item_t it;
    it.req = REQ_BYTE; it.ch = c[7:0]; it.clr = 8'($urandom);
    byte_q.push_back(it);
  endtask

  task automatic add_clear(int unsigned clr);
    term_item_t it;
    it.req = REQ_RESET; it.ch = 8'($urandom); it.clr = clr[7:0];
    byte_q.push_back(it);
  endtask

  task automatic add_num(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // ESC [ params final, with up to three numeric parameters
  task automatic add_csi(bit q, int np, int unsigned v0, int unsigned v1,
                         int unsigned v2, int unsigned fin);
    add_byte(CH_ESC);
    add_byte(CH_LBRK);
    if (q) add_byte(CH_QMARK);
    if (np > 0) add_num(v0);
    if (np > 1) begin
      add_byte(CH_SEMI); add_num(v1);
    end
    if (np > 2) begin
      add_byte(CH_SEMI); add_num(v2);
    end
    add_byte(fin);
  endtask

  function automatic int unsigned rand_param();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 60) return $urandom_range(9);
    if (k < 85) return $urandom_range(110);
    if (k < 95) return $urandom_range(300);
    return $urandom_range(99999, 65530);
  endfunction

  function automatic int unsigned rand_final();
    int unsigned fins[13];
    fins = '{CSI_CUU, CSI_CUD, CSI_CUF, CSI_CUB, CSI_CHA, CSI_CUP, CSI_HVP, CSI_ED,
             CSI_EL, CSI_SGR, CSI_SM, CSI_RM, FINAL_HI};
    if ($urandom_range(9) == 0) return $urandom_range(FINAL_HI, FINAL_LO);
    return fins[$urandom_range(12)];
  endfunction

  task automatic add_random_burst();
    int unsigned k, c;
    k = $urandom_range(99);
    if (k < 45) begin
      add_csi($urandom_range(5) == 0, $urandom_range(3), rand_param(), rand_param(),
              rand_param(), rand_final());
    end else if (k < 70) begin
      repeat ($urandom_range(4, 1)) add_byte($urandom_range(255, 32));
    end else if (k < 82) begin
      case ($urandom_range(5))
        0: add_byte(CH_LF);
        1: add_byte(CH_CR);
        2: add_byte(CH_BS);
        3: add_byte(CH_DEL);
        4: add_byte(CH_TAB);
        default: add_byte($urandom_range(31));
      endcase
    end else if (k < 86) begin
      add_clear($urandom);
    end else if (k < 93) begin
      add_byte($urandom);
    end else begin
      // broken sequences
      add_byte(CH_ESC);
      if ($urandom_range(1)) begin
        add_byte(CH_LBRK);
        add_num(rand_param());
      end
      c = $urandom;
      while (c == CH_LBRK || (c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI ||
             c == CH_QMARK || (c >= FINAL_LO && c <= FINAL_HI)) c = $urandom;
      add_byte(c);
    end
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_COLUMNS) m_cols = val;
    else if (idx == REG_ROWS) m_rows = val[7:0];
    else if (idx == REG_DEFCOL) m_defcol = val[7:0];
  endtask

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (in_valid_i && !in_stall_o) predict_item(shown);
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && byte_q.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
        shown = byte_q.pop_front();
        in_valid_i    <= 1'b1;
        req_type_i    <= shown.req;
        char_code_i   <= shown.ch;
        clear_color_i <= shown.clr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor, receiver stalls and watchdog ----------------
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    screen_cmd_t got, exp_cmd;
    bit moved;
    moved = (in_valid_i && !in_stall_o) || (cfg_valid_i && cfg_ready_o);
    if (out_valid_o && !out_stall_i) begin
      moved = 1;
      got = '{op_o, start_pos_o, end_pos_o, char_code_out_o, color_o, cursor_pos_o,
              cursor_on_o, last_o};
      results_seen++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        exp_cmd = want_q.pop_front();
        if (got !== exp_cmd) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", exp_cmd, got);
        end
      end
    end
    // one long hold-off so the engine backs up into its input
    if (!hold_done && results_seen >= 60) begin
      hold_done = 1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 30);
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    logic [8:0] col_set[7];
    logic [8:0] row_set[7];
    logic [8:0] def_set[7];
    col_set = '{80, 1, 256, 8, 20, 0, 400};
    row_set = '{25, 1, 128, 3, 5, 0, 200};
    def_set = '{7, 0, 255, 9'h11f, 9'h04a, 9'h1f0, 9'h0c3};
    parser_clear();
    for (int i = 0; i < MAX_PARAMS_TB; i++) plist[i] = 0;
    sgr_default();
    dcolor = m_defcol; cursor = 0; cen = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes of the fields and most commands
    add_clear(8'h00);
    add_byte(CH_SPACE); add_byte("A"); add_byte(FINAL_HI); add_byte(8'hff);
    add_byte(CH_TAB); add_byte(CH_BS); add_byte(CH_DEL); add_byte(CH_LF);
    add_byte(CH_CR); add_byte(8'h00);
    add_csi(0, 2, 30, 41, 0, CSI_SGR);
    add_csi(0, 3, 1, 7, 95, CSI_SGR);
    add_csi(0, 2, 3, 5, 0, CSI_CUP);
    add_csi(0, 1, 99999, 0, 0, CSI_CUF);
    add_csi(0, 0, 0, 0, 0, CSI_CUU);
    add_csi(1, 1, 25, 0, 0, CSI_RM);
    add_csi(0, 1, 25, 0, 0, CSI_SM);
    add_csi(1, 1, 25, 0, 0, CSI_SM);
    add_csi(0, 1, 1, 0, 0, CSI_ED);
    add_csi(0, 1, 2, 0, 0, CSI_EL);
    add_byte(CH_ESC); add_byte("x");
    add_byte(CH_ESC); add_byte(CH_LBRK); add_byte(8'h01);
    add_byte(CH_ESC); add_byte(CH_LBRK);
    for (int i = 1; i <= 6; i++) begin
      add_num(i); add_byte(CH_SEMI);
    end
    add_byte(CSI_HVP);
    add_clear(8'hff);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_idle();
        write_reg(REG_COLUMNS, col_set[ph]);
        write_reg(REG_ROWS, row_set[ph]);
        write_reg(REG_DEFCOL, def_set[ph]);
      end
      repeat (14) add_random_burst();
    end
    wait_idle();

    if (errors == 0 && want_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ate_pkg.sv
rtl/ate_ctrl.sv
rtl/ate_datapath.sv
rtl/ansi_text_terminal_engine.sv
tb/tb_ansi_text_terminal_engine.sv
